// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");

// next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: label");

`endif

// ----- sv/rcida_pkg.sv -----
// ----------------------------------------------------------------------------
// rcida_pkg
// Types and constants of the reference-counted identifier allocator.
// ----------------------------------------------------------------------------
package rcida_pkg;

   localparam int NUM_IDS_DEF = 256;
   localparam int COUNT_W_DEF = 16;
   localparam int IDENT_W     = 8;
   localparam int REF_START   = 1;

   typedef enum logic [1:0] {
      CMD_GENERATE  = 2'd0,
      CMD_INCREMENT = 2'd1,
      CMD_DECREMENT = 2'd2,
      CMD_CONTAINS  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type              command;
      logic [IDENT_W-1:0]   ident;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [IDENT_W-1:0]   new_ident;
      logic                 present;
   } rsp_type;

   typedef enum logic {
      UNIT_INC = 1'b0,
      UNIT_DEC = 1'b1
   } unit_op_type;

   // flags reported by the count unit alongside its result
   typedef struct packed {
      logic zero;
      logic at_one;
   } unit_flags_type;

endpackage

// ----- sv/rcida_ram.sv -----
// ----------------------------------------------------------------------------
// rcida_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcida_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rcida_unit.sv -----
// ----------------------------------------------------------------------------
// rcida_unit
// Shared count unit: saturating increment or decrement, plus zero and
// at-or-below-one flags used by lookups and by the released-identifier scan.
// ----------------------------------------------------------------------------
module rcida_unit import rcida_pkg::*; #(
   parameter int COUNT_W = COUNT_W_DEF
) (
   input  unit_op_type          op,
   input  logic [COUNT_W-1:0]   count,
   output logic [COUNT_W-1:0]   result,
   output unit_flags_type       flags
);

   logic is_max;

   assign is_max       = (count == {COUNT_W{1'b1}});
   assign flags.zero   = (count == '0);
   assign flags.at_one = (count <= COUNT_W'(REF_START));

   always_comb begin
      unique case (op)
         UNIT_INC: result = is_max ? count : count + 1'b1;
         UNIT_DEC: result = flags.at_one ? '0 : count - 1'b1;
         default:  result = count;
      endcase
   end

endmodule

// ----- sv/refcounted_id_allocator_top.sv -----
// ----------------------------------------------------------------------------
// refcounted_id_allocator_top
// Reference-counted identifier allocator with a count RAM and a small
// sequencer around one shared count unit.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on rsp_data for exactly one cycle with rsp_strobe high, and must be
// taken then since the receiver cannot stall. A generate is answered in the
// cycle after it is taken. Increment, decrement and contains of a nonzero
// identifier read the count RAM once and answer from S_LOOK through the
// response register. A generate that reuses a released identifier while
// others stay released then scans the count RAM upward from it for the next
// released one, each entry read through the RAM's registered port and then
// checked in the count unit; busy stays high during that scan. No clearing
// pass follows reset: the fresh-identifier counter marks written entries.
// ----------------------------------------------------------------------------
module refcounted_id_allocator_top import rcida_pkg::*; #(
   parameter int NUM_IDS = NUM_IDS_DEF,
   parameter int COUNT_W = COUNT_W_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int ID_W  = $clog2(NUM_IDS);
   localparam int CMP_W = (ID_W + 1 > IDENT_W) ? ID_W + 1 : IDENT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_SCAN_RD,
      S_SCAN_CHK
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic [ID_W:0]      next_fresh_ff, next_fresh_in;
   logic [ID_W:0]      rel_cnt_ff, rel_cnt_in;
   logic [ID_W-1:0]    min_ff, min_in;
   logic [ID_W-1:0]    scan_ff, scan_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               ram_we;
   logic [ID_W-1:0]    ram_waddr;
   logic [COUNT_W-1:0] ram_wdata;
   logic [ID_W-1:0]    ram_raddr;
   logic [COUNT_W-1:0] ram_rdata;

   unit_op_type        unit_op;
   logic [COUNT_W-1:0] unit_result;
   unit_flags_type     unit_flags;

   logic [CMP_W-1:0]   ident_wide_ff;
   logic [CMP_W-1:0]   fresh_wide;
   logic [ID_W-1:0]    ident_addr_ff;
   logic               live;

   rcida_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_IDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rcida_unit #(
      .COUNT_W (COUNT_W)
   ) u_unit (
      .op     (unit_op),
      .count  (ram_rdata),
      .result (unit_result),
      .flags  (unit_flags)
   );

   assign ident_wide_ff = CMP_W'(ident_ff);
   assign fresh_wide    = CMP_W'(next_fresh_ff);
   assign ident_addr_ff = ident_wide_ff[ID_W-1:0];
   // entries at or above the fresh counter were never written
   assign live          = (ident_wide_ff < fresh_wide) && !unit_flags.zero;
   assign unit_op       = (cmd_ff == CMD_INCREMENT) ? UNIT_INC : UNIT_DEC;

   always_comb begin
      logic [CMP_W-1:0] req_wide;
      req_wide      = CMP_W'(req_data.ident);
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ident_in      = ident_ff;
      next_fresh_in = next_fresh_ff;
      rel_cnt_in    = rel_cnt_ff;
      min_in        = min_ff;
      scan_in       = scan_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = ident_addr_ff;
      ram_wdata     = unit_result;
      ram_raddr     = req_wide[ID_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.command;
               ident_in = req_data.ident;
               rsp_in   = '{status: ST_OK, new_ident: '0, present: 1'b0};
               if (req_data.command == CMD_GENERATE) begin
                  rsp_strobe_in = 1'b1;
                  if (rel_cnt_ff != '0) begin
                     ram_we           = 1'b1;
                     ram_waddr        = min_ff;
                     ram_wdata        = COUNT_W'(REF_START);
                     rsp_in.new_ident = IDENT_W'(min_ff);
                     rel_cnt_in       = rel_cnt_ff - 1'b1;
                     if (rel_cnt_ff != (ID_W+1)'(1)) begin
                        scan_in  = min_ff + 1'b1;
                        state_in = S_SCAN_RD;
                     end
                  end else if (next_fresh_ff < (ID_W+1)'(NUM_IDS)) begin
                     ram_we           = 1'b1;
                     ram_waddr        = next_fresh_ff[ID_W-1:0];
                     ram_wdata        = COUNT_W'(REF_START);
                     rsp_in.new_ident = IDENT_W'(next_fresh_ff);
                     next_fresh_in    = next_fresh_ff + 1'b1;
                  end else begin
                     rsp_in.status = ST_EXHAUSTED;
                  end
               end else if (req_data.ident == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.status = ST_INVALID;
               end else begin
                  state_in = S_LOOK;
               end
            end
         end

         S_LOOK: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (cmd_ff == CMD_CONTAINS) begin
               rsp_in.present = live;
            end else if (!live) begin
               rsp_in.status = ST_NOT_FOUND;
            end else begin
               ram_we = 1'b1;
               if (cmd_ff == CMD_DECREMENT && unit_flags.at_one) begin
                  rel_cnt_in = rel_cnt_ff + 1'b1;
                  if (rel_cnt_ff == '0 || ident_addr_ff < min_ff) begin
                     min_in = ident_addr_ff;
                  end
               end
            end
         end

         S_SCAN_RD: begin
            ram_raddr = scan_ff;
            state_in  = S_SCAN_CHK;
         end

         S_SCAN_CHK: begin
            // a zero count below the fresh counter is a released identifier
            if (unit_flags.zero) begin
               min_in   = scan_ff;
               state_in = S_IDLE;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_fresh_ff <= (ID_W+1)'(REF_START);
         rel_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_fresh_ff <= next_fresh_in;
         rel_cnt_ff    <= rel_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff   <= cmd_in;
      ident_ff <= ident_in;
      min_ff   <= min_in;
      scan_ff  <= scan_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- sv/rcida_checker.sv -----
// ----------------------------------------------------------------------------
// rcida_checker
// Port-level checks of the identifier allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcida_checker import rcida_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic beat_in;

   assign beat_in = start && !busy;

   // every accepted beat is either answered next cycle or keeps the block busy
   `ASSERT_NEXT(a_accept_progress, clock, reset, beat_in, rsp_strobe || busy)

   // failures carry no issued identifier and no presence flag
   `ASSERT_IMPLIES(a_fail_clean, clock, reset, rsp_strobe && rsp_data.status != ST_OK, rsp_data.new_ident == '0 && !rsp_data.present)

   // a presence answer never comes with an issued identifier
   `ASSERT_IMPLIES(a_present_ok, clock, reset, rsp_strobe && rsp_data.present, rsp_data.status == ST_OK && rsp_data.new_ident == '0)

   // reset leaves the block idle with no result pending
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !busy && !rsp_strobe)

endmodule

bind refcounted_id_allocator_top rcida_checker u_rcida_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- tb/sv/tb_refcounted_id_allocator_top.sv -----
// ----------------------------------------------------------------------------
// tb_refcounted_id_allocator_top
// Self-checking bench for the reference-counted identifier allocator. A
// directed prologue hits identifier zero, unknown identifiers, contains,
// release and reuse. It then fills the whole identifier space until generate
// reports exhausted. Random churn follows: reuse scans, increment bursts and
// noise. Every answer is checked against a behavioral shadow of the count
// table.
// ----------------------------------------------------------------------------
module tb_refcounted_id_allocator_top;
   import rcida_pkg::*;

   localparam int NUM_IDS        = NUM_IDS_DEF;
   localparam int CNT_W          = COUNT_W_DEF;
   localparam int BURST_LEN      = 4;
   localparam int IDLE_PCT       = 31;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 600;
   localparam int FILL_ITEMS     = 260;
   localparam int CHURN_ITEMS    = 440;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // shadow of the allocator
   logic [CNT_W-1:0] use_count [NUM_IDS];
   bit               freed     [NUM_IDS];
   logic [8:0]       fresh_id;

   req_type cmd_backlog[$];
   rsp_type awaited_answers[$];

   bit steady;
   int idle_cycles;
   int errors;
   int beats;
   int reuse_hits;
   int exhausted_hits;
   int saturated_hits;
   int release_hits;

   refcounted_id_allocator_top #(
      .NUM_IDS (NUM_IDS),
      .COUNT_W (CNT_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected answer to one command; updates the shadow table
   function automatic rsp_type apply_command(req_type cmd);
      rsp_type    ans;
      int         k;
      bit         found;
      logic [7:0] id;
      ans       = '0;
      ans.status = ST_OK;
      id        = cmd.ident;
      found     = 1'b0;
      if (cmd.command == CMD_GENERATE) begin
         for (k = 1; k < NUM_IDS; k++) begin
            if (!found && freed[k]) begin
               freed[k]      = 1'b0;
               use_count[k]  = CNT_W'(REF_START);
               ans.new_ident = 8'(k);
               found         = 1'b1;
               reuse_hits++;
            end
         end
         if (!found) begin
            if (fresh_id < NUM_IDS) begin
               use_count[fresh_id[7:0]] = CNT_W'(REF_START);
               ans.new_ident            = fresh_id[7:0];
               fresh_id                 = fresh_id + 9'd1;
            end else begin
               ans.status = ST_EXHAUSTED;
               exhausted_hits++;
            end
         end
      end else if (id == '0) begin
         ans.status = ST_INVALID;
      end else if (cmd.command == CMD_CONTAINS) begin
         ans.present = (use_count[id] != '0);
      end else if (use_count[id] == '0) begin
         ans.status = ST_NOT_FOUND;
      end else if (cmd.command == CMD_INCREMENT) begin
         if (use_count[id] != '1) use_count[id] = use_count[id] + 1'b1;
         else saturated_hits++;
      end else if (use_count[id] <= CNT_W'(REF_START)) begin
         use_count[id] = '0;
         freed[id]     = 1'b1;
         release_hits++;
      end else begin
         use_count[id] = use_count[id] - 1'b1;
      end
      return ans;
   endfunction

   // random live identifier, zero when none is live
   function automatic logic [7:0] pick_live();
      int         base;
      int         k;
      logic [7:0] id;
      base = $urandom_range(NUM_IDS - 1);
      for (k = 0; k < NUM_IDS; k++) begin
         id = 8'(base + k);
         if (id != '0 && use_count[id] != '0) return id;
      end
      return '0;
   endfunction

   task automatic queue_cmd(cmd_type c, logic [7:0] id);
      req_type item;
      while (cmd_backlog.size() >= 2) @(negedge clock);
      item.command = c;
      item.ident   = id;
      cmd_backlog.push_back(item);
   endtask

   // driver: a new beat is presented only once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (cmd_backlog.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_data <= cmd_backlog.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict on every accepted beat, check every strobed answer
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (start && !busy) begin
            awaited_answers.push_back(apply_command(req_data));
            beats++;
         end
         if (rsp_strobe) begin
            if (awaited_answers.size() == 0) begin
               errors++;
               $display("%0t: unexpected answer status %s new_ident %0d present %0b",
                        $time, rsp_data.status.name(), rsp_data.new_ident,
                        rsp_data.present);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.new_ident !== want.new_ident
                   || rsp_data.present !== want.present) begin
                  errors++;
                  $display("%0t: expected %s/%0d/%0b got %s/%0d/%0b",
                           $time, want.status.name(), want.new_ident, want.present,
                           rsp_data.status.name(), rsp_data.new_ident, rsp_data.present);
               end
            end
         end
         if ((start && !busy) || rsp_strobe) idle_cycles = 0;
         else idle_cycles = idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("refcounted_id_allocator_top: mismatch");
      $finish;
   end

   initial begin
      int         n;
      int         r;
      int         j;
      logic [7:0] id;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      steady   = 1'b0;
      errors   = 0;
      beats    = 0;
      reuse_hits     = 0;
      exhausted_hits = 0;
      saturated_hits = 0;
      release_hits   = 0;
      idle_cycles    = 0;
      fresh_id       = 9'd1;
      for (n = 0; n < NUM_IDS; n++) begin
         use_count[n] = '0;
         freed[n]     = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // identifier zero, unknown identifiers, then issue, release and reuse
      queue_cmd(CMD_CONTAINS,  8'd0);
      queue_cmd(CMD_INCREMENT, 8'd0);
      queue_cmd(CMD_DECREMENT, 8'd0);
      queue_cmd(CMD_CONTAINS,  8'd255);
      queue_cmd(CMD_INCREMENT, 8'd255);
      queue_cmd(CMD_DECREMENT, 8'd128);
      queue_cmd(CMD_GENERATE,  8'd255);
      queue_cmd(CMD_GENERATE,  8'd0);
      queue_cmd(CMD_GENERATE,  8'd170);
      queue_cmd(CMD_CONTAINS,  8'd2);
      queue_cmd(CMD_INCREMENT, 8'd2);
      queue_cmd(CMD_DECREMENT, 8'd2);
      queue_cmd(CMD_DECREMENT, 8'd1);
      queue_cmd(CMD_DECREMENT, 8'd3);
      queue_cmd(CMD_DECREMENT, 8'd1);
      queue_cmd(CMD_CONTAINS,  8'd1);
      queue_cmd(CMD_GENERATE,  8'd85);
      queue_cmd(CMD_GENERATE,  8'd0);
      queue_cmd(CMD_GENERATE,  8'd0);
      queue_cmd(CMD_CONTAINS,  8'd4);

      // use up the whole space, a few generates past the end
      for (n = 0; n < FILL_ITEMS; n++) queue_cmd(CMD_GENERATE, 8'($urandom_range(255)));

      for (n = 0; n < CHURN_ITEMS; n++) begin
         steady = (n >= 200 && n < 320);
         r = $urandom_range(99);
         if (r < 25) begin
            queue_cmd(CMD_GENERATE, 8'($urandom_range(255)));
         end else if (r < 45) begin
            queue_cmd(CMD_DECREMENT, pick_live());
         end else if (r < 60) begin
            queue_cmd(CMD_INCREMENT, pick_live());
         end else if (r < 70) begin
            if ($urandom_range(1)) queue_cmd(CMD_CONTAINS, pick_live());
            else queue_cmd(CMD_CONTAINS, 8'($urandom_range(1, 255)));
         end else if (r < 73) begin
            // short burst of increments on one identifier
            id = pick_live();
            for (j = 0; j < BURST_LEN; j++) queue_cmd(CMD_INCREMENT, id);
         end else begin
            queue_cmd(cmd_type'($urandom_range(3)), 8'($urandom_range(255)));
         end
      end
      steady = 1'b0;

      while (cmd_backlog.size() != 0 || start || awaited_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands: %0d reuses, %0d releases, %0d exhausted",
               beats, reuse_hits, release_hits, exhausted_hits);
      $display("%0d increments held at the count limit", saturated_hits);
      if (errors == 0) begin
         $display("refcounted_id_allocator_top: match");
      end else begin
         $display("refcounted_id_allocator_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- refcounted_id_allocator_top.f -----
+incdir+sv
sv/rcida_pkg.sv
sv/rcida_ram.sv
sv/rcida_unit.sv
sv/refcounted_id_allocator_top.sv
sv/rcida_checker.sv
tb/sv/tb_refcounted_id_allocator_top.sv
